### rtl/handheld_io_register_bank_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the I/O register bank.
// ---------------------------------------------------------------------------
`ifndef HANDHELD_IO_REGISTER_BANK_MACROS_SVH
`define HANDHELD_IO_REGISTER_BANK_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define HIRB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define HIRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/hirb_pkg.sv
// ---------------------------------------------------------------------------
// hirb_pkg
// Shared types and register addresses of the I/O register bank.
// ---------------------------------------------------------------------------
package hirb_pkg;

  localparam logic [15:0] A_P1   = 16'hFF00;
  localparam logic [15:0] A_SB   = 16'hFF01;
  localparam logic [15:0] A_SC   = 16'hFF02;
  localparam logic [15:0] A_DIV  = 16'hFF04;
  localparam logic [15:0] A_TIMA = 16'hFF05;
  localparam logic [15:0] A_TMA  = 16'hFF06;
  localparam logic [15:0] A_TAC  = 16'hFF07;
  localparam logic [15:0] A_NR10 = 16'hFF10;
  localparam logic [15:0] A_NR11 = 16'hFF11;
  localparam logic [15:0] A_NR12 = 16'hFF12;
  localparam logic [15:0] A_NR13 = 16'hFF13;
  localparam logic [15:0] A_NR14 = 16'hFF14;
  localparam logic [15:0] A_NR21 = 16'hFF16;
  localparam logic [15:0] A_NR22 = 16'hFF17;
  localparam logic [15:0] A_NR23 = 16'hFF18;
  localparam logic [15:0] A_NR24 = 16'hFF19;
  localparam logic [15:0] A_NR30 = 16'hFF1A;
  localparam logic [15:0] A_NR31 = 16'hFF1B;
  localparam logic [15:0] A_NR32 = 16'hFF1C;
  localparam logic [15:0] A_NR33 = 16'hFF1D;
  localparam logic [15:0] A_NR34 = 16'hFF1E;
  localparam logic [15:0] A_NR41 = 16'hFF20;
  localparam logic [15:0] A_NR42 = 16'hFF21;
  localparam logic [15:0] A_NR43 = 16'hFF22;
  localparam logic [15:0] A_NR44 = 16'hFF23;
  localparam logic [15:0] A_NR50 = 16'hFF24;
  localparam logic [15:0] A_NR51 = 16'hFF25;
  localparam logic [15:0] A_NR52 = 16'hFF26;
  localparam logic [15:0] A_LCDC = 16'hFF40;
  localparam logic [15:0] A_STAT = 16'hFF41;
  localparam logic [15:0] A_SCY  = 16'hFF42;
  localparam logic [15:0] A_SCX  = 16'hFF43;
  localparam logic [15:0] A_LY   = 16'hFF44;
  localparam logic [15:0] A_LYC  = 16'hFF45;
  localparam logic [15:0] A_DMA  = 16'hFF46;
  localparam logic [15:0] A_BGP  = 16'hFF47;
  localparam logic [15:0] A_OBP0 = 16'hFF48;
  localparam logic [15:0] A_OBP1 = 16'hFF49;
  localparam logic [15:0] A_WY   = 16'hFF4A;
  localparam logic [15:0] A_WX   = 16'hFF4B;
  localparam logic [15:0] A_BOOT = 16'hFF50;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Command from controller to datapath.
  typedef struct packed {
    logic capture;
    logic drain;
  } hirb_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic result_ready;
  } hirb_sts_t;

endpackage

### rtl/hirb_ctrl.sv
// ---------------------------------------------------------------------------
// hirb_ctrl
// Handshake controller: one-entry output register with pass-through refill.
// ---------------------------------------------------------------------------
module hirb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output hirb_pkg::hirb_cmd_t cmd,
  input  hirb_pkg::hirb_sts_t sts
);
  import hirb_pkg::*;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_FULL  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  assign in_stall  = (state_r == ST_FULL) && out_stall;
  assign take      = in_valid && !in_stall;
  assign out_valid = (state_r == ST_FULL);
  assign cmd.capture = take;
  assign cmd.drain   = out_valid && !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_EMPTY: if (take) state_nxt = ST_FULL;
      ST_FULL: begin
        if (!out_stall && !take) state_nxt = ST_EMPTY;
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_EMPTY;
    else state_r <= state_nxt;
  end

`include "handheld_io_register_bank_macros.svh"
  `HIRB_ASSERT_NEXT(a_take_full, clk, rst_n, take, out_valid)
  `HIRB_ASSERT_IMP(a_sts_match, clk, rst_n, 1'b1, sts.result_ready == out_valid)
  `HIRB_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid)
endmodule

### rtl/hirb_dp.sv
// ---------------------------------------------------------------------------
// hirb_dp
// Register storage, address decode, read packing and write pulses.
// ---------------------------------------------------------------------------
module hirb_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  hirb_pkg::hirb_cmd_t cmd,
  output hirb_pkg::hirb_sts_t sts,
  input  logic              in_operation,
  input  logic [15:0]       in_address,
  input  logic [7:0]        in_write_data,
  input  logic [3:0]        in_joypad_lines,
  input  logic [7:0]        in_divider_now,
  input  logic [7:0]        in_timer_count_now,
  input  logic [3:0]        in_channel_on_flags,
  input  logic [1:0]        in_lcd_mode_now,
  input  logic              in_coincidence_now,
  input  logic [7:0]        in_line_now,
  output logic [7:0]        out_read_data,
  output logic              out_hit,
  output logic              out_divider_clear,
  output logic              out_timer_load,
  output logic [7:0]        out_timer_load_value,
  output logic              out_line_restart,
  output logic              out_boot_rom_off
);
  import hirb_pkg::*;

  logic [1:0]  joyp_r;
  logic [7:0]  sb_r;
  logic [1:0]  sc_r;
  logic [7:0]  tma_r;
  logic [2:0]  tac_r;
  logic        nr52_r;
  logic [6:0]  sweep_r;
  logic [7:0]  duty_r [2];
  logic [7:0]  env_r [3];
  logic [10:0] freq_r [3];
  logic [1:0]  let_r [4];
  logic [10:0] wave_r;
  logic [15:0] noise_r;
  logic [15:0] vol_r;
  logic [7:0]  lcdc_r;
  logic [3:0]  stat_r;
  logic [7:0]  scr_r [3];
  logic [7:0]  bgp_r;
  logic [5:0]  obp_r [2];
  logic [7:0]  win_r [2];
  logic        full_r;

  logic [7:0] rd;
  logic       hit, wr, we, snd;
  logic [7:0] d;

  assign d   = in_write_data;
  assign wr  = in_operation == OP_WRITE;
  assign snd = (in_address >= A_NR10) && (in_address <= A_NR51);
  assign we  = cmd.capture && wr && !(snd && !nr52_r);

  always_comb begin
    rd  = 8'h00;
    hit = 1'b1;
    case (in_address)
      A_P1:   rd = {2'b00, joyp_r, in_joypad_lines};
      A_SB:   rd = sb_r;
      A_SC:   rd = {sc_r[1], 6'b0, sc_r[0]};
      A_DIV:  rd = in_divider_now;
      A_TIMA: rd = in_timer_count_now;
      A_TMA:  rd = tma_r;
      A_TAC:  rd = {5'b0, tac_r};
      A_NR10: rd = {1'b0, sweep_r};
      A_NR11: rd = duty_r[0] & 8'hC0;
      A_NR12: rd = env_r[0];
      A_NR14: rd = {1'b0, let_r[0][0], 6'b0};
      A_NR21: rd = duty_r[1] & 8'hC0;
      A_NR22: rd = env_r[1];
      A_NR24: rd = {1'b0, let_r[1][0], 6'b0};
      A_NR30: rd = {wave_r[10], 7'b0};
      A_NR31: rd = wave_r[7:0];
      A_NR32: rd = {1'b0, wave_r[9:8], 5'b0};
      A_NR34: rd = {1'b0, let_r[2][0], 6'b0};
      A_NR41: rd = noise_r[7:0];
      A_NR42: rd = env_r[2];
      A_NR43: rd = noise_r[15:8];
      A_NR44: rd = {1'b0, let_r[3][0], 6'b0};
      A_NR50: rd = vol_r[7:0];
      A_NR51: rd = vol_r[15:8];
      A_NR52: rd = {nr52_r, 3'b0, in_channel_on_flags};
      A_LCDC: rd = lcdc_r;
      A_STAT: rd = {1'b0, stat_r, in_coincidence_now, in_lcd_mode_now};
      A_SCY:  rd = scr_r[0];
      A_SCX:  rd = scr_r[1];
      A_LY:   rd = in_line_now;
      A_LYC:  rd = scr_r[2];
      A_BGP:  rd = bgp_r;
      A_OBP0: rd = {obp_r[0], 2'b00};
      A_OBP1: rd = {obp_r[1], 2'b00};
      A_WY:   rd = win_r[0];
      A_WX:   rd = win_r[1];
      A_NR13, A_NR23, A_NR33, A_DMA, A_BOOT: rd = 8'h00;
      default: hit = 1'b0;
    endcase
  end

  // Stored registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joyp_r <= '0; sb_r <= '0; sc_r <= '0; tma_r <= '0; tac_r <= '0;
      nr52_r <= 1'b0; sweep_r <= '0; wave_r <= '0; noise_r <= '0; vol_r <= '0;
      lcdc_r <= '0; stat_r <= '0; bgp_r <= '0;
      for (int i = 0; i < 2; i++) begin
        duty_r[i] <= '0; obp_r[i] <= '0; win_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        env_r[i] <= '0; freq_r[i] <= '0; scr_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) let_r[i] <= '0;
    end else if (we) begin
      case (in_address)
        A_P1:   joyp_r <= d[5:4];
        A_SB:   sb_r <= d;
        A_SC:   sc_r <= {d[7], d[0]};
        A_TMA:  tma_r <= d;
        A_TAC:  tac_r <= d[2:0];
        A_NR10: sweep_r <= d[6:0];
        A_NR11: duty_r[0] <= d;
        A_NR12: env_r[0] <= d;
        A_NR13: freq_r[0][7:0] <= d;
        A_NR14: begin freq_r[0][10:8] <= d[2:0]; let_r[0] <= d[7:6]; end
        A_NR21: duty_r[1] <= d;
        A_NR22: env_r[1] <= d;
        A_NR23: freq_r[1][7:0] <= d;
        A_NR24: begin freq_r[1][10:8] <= d[2:0]; let_r[1] <= d[7:6]; end
        A_NR30: wave_r[10] <= d[7];
        A_NR31: wave_r[7:0] <= d;
        A_NR32: wave_r[9:8] <= d[6:5];
        A_NR33: freq_r[2][7:0] <= d;
        A_NR34: begin freq_r[2][10:8] <= d[2:0]; let_r[2] <= d[7:6]; end
        A_NR41: noise_r[7:0] <= d;
        A_NR42: env_r[2] <= d;
        A_NR43: noise_r[15:8] <= d;
        A_NR44: let_r[3] <= d[7:6];
        A_NR50: vol_r[7:0] <= d;
        A_NR51: vol_r[15:8] <= d;
        A_NR52: nr52_r <= d[7];
        A_LCDC: lcdc_r <= d;
        A_STAT: stat_r <= d[6:3];
        A_SCY:  scr_r[0] <= d;
        A_SCX:  scr_r[1] <= d;
        A_LYC:  scr_r[2] <= d;
        A_BGP:  bgp_r <= d;
        A_OBP0: obp_r[0] <= d[7:2];
        A_OBP1: obp_r[1] <= d[7:2];
        A_WY:   win_r[0] <= d;
        A_WX:   win_r[1] <= d;
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_read_data        <= wr ? 8'h00 : rd;
      out_hit              <= hit;
      out_divider_clear    <= wr && in_address == A_DIV;
      out_timer_load       <= wr && (in_address == A_TIMA || in_address == A_TAC);
      out_timer_load_value <= (wr && in_address == A_TIMA) ? d : 8'h00;
      out_line_restart     <= wr && in_address == A_LY;
      out_boot_rom_off     <= wr && in_address == A_BOOT;
    end
  end

  // The result register is full from a capture until the controller drains it.
  always_ff @(posedge clk) begin
    if (!rst_n) full_r <= 1'b0;
    else if (cmd.capture) full_r <= 1'b1;
    else if (cmd.drain) full_r <= 1'b0;
  end

  assign sts.result_ready = full_r;

`include "handheld_io_register_bank_macros.svh"
  `HIRB_ASSERT_NEXT(a_snd_gate, clk, rst_n,
    cmd.capture && wr && snd && !nr52_r && in_address == A_NR50, $stable(vol_r))
  `HIRB_ASSERT_NEXT(a_wr_rd0, clk, rst_n, cmd.capture && wr, out_read_data == 8'h00)
  `HIRB_ASSERT_NEXT(a_load_val, clk, rst_n, cmd.capture && !wr, !out_timer_load)
endmodule

### rtl/handheld_io_register_bank.sv
// ---------------------------------------------------------------------------
// handheld_io_register_bank
// Memory-mapped I/O register bank at 0xFF00 to 0xFF50 of a handheld console.
// ---------------------------------------------------------------------------
//  Channel   Ports                          Direction
//  in        in_valid / in_stall + fields   bus access transaction in
//  out       out_valid / out_stall + fields result transaction out
//
// Each transaction is decoded and answered combinationally; its result appears
// in the output register on the next cycle. A new transaction is accepted every
// cycle unless a held result is stalled. Reset is synchronous and active low
// and clears every stored register to zero, but not the result register. While
// a held result is stalled the input is stalled too, so the held result and all
// register contents stay unchanged.
module handheld_io_register_bank (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_operation,
  input  logic [15:0] in_address,
  input  logic [7:0] in_write_data,
  input  logic [3:0] in_joypad_lines,
  input  logic [7:0] in_divider_now,
  input  logic [7:0] in_timer_count_now,
  input  logic [3:0] in_channel_on_flags,
  input  logic [1:0] in_lcd_mode_now,
  input  logic       in_coincidence_now,
  input  logic [7:0] in_line_now,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_hit,
  output logic       out_divider_clear,
  output logic       out_timer_load,
  output logic [7:0] out_timer_load_value,
  output logic       out_line_restart,
  output logic       out_boot_rom_off
);
  import hirb_pkg::*;

  hirb_cmd_t cmd;
  hirb_sts_t sts;

  // Controller owns the handshake; the datapath holds all I/O and result registers.
  hirb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  hirb_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_operation(in_operation), .in_address(in_address),
    .in_write_data(in_write_data), .in_joypad_lines(in_joypad_lines),
    .in_divider_now(in_divider_now), .in_timer_count_now(in_timer_count_now),
    .in_channel_on_flags(in_channel_on_flags), .in_lcd_mode_now(in_lcd_mode_now),
    .in_coincidence_now(in_coincidence_now), .in_line_now(in_line_now),
    .out_read_data(out_read_data), .out_hit(out_hit),
    .out_divider_clear(out_divider_clear), .out_timer_load(out_timer_load),
    .out_timer_load_value(out_timer_load_value),
    .out_line_restart(out_line_restart), .out_boot_rom_off(out_boot_rom_off)
  );
endmodule
